[rtl/core/sfe_pkg.sv]
// Shared types, constants and the digit segment table for the segment frame encoder.
// No dependencies.
package sfe_pkg;

    localparam int unsigned FRAME_BYTES = 15;
    localparam int unsigned LOW_BYTES   = 8;
    localparam int unsigned HIGH_BYTES  = FRAME_BYTES - LOW_BYTES;

    localparam logic signed [12:0] TEMP_MAX  = 13'sd1999;
    localparam logic signed [12:0] TEMP_MIN  = -13'sd999;
    localparam logic signed [12:0] TEMP_HUND = 13'sd1000;
    localparam logic signed [11:0] HUM_MAX   = 12'sd999;

    localparam logic [7:0] MARK_HUNDREDS = 8'h1f;
    localparam logic [7:0] MARK_MINUS    = 8'h04;
    localparam logic [7:0] MARK_NONE     = 8'h00;
    localparam logic [7:0] DOT_MARK      = 8'h20;
    localparam logic [7:0] ICON_BASE     = 8'h04;
    localparam logic [7:0] ICON_FAHR     = 8'h02;
    localparam logic [7:0] ICON_CELS     = 8'h01;
    localparam logic [7:0] ICON_LINK     = 8'h08;
    localparam logic [7:0] ICON_BATT     = 8'h10;
    localparam logic [7:0] TAIL_BYTE     = 8'h00;

    // Reciprocal constants for exact division of values up to 2047
    localparam logic [12:0] RECIP_10  = 13'd6554;  // x*RECIP_10  >> 16 == x/10
    localparam logic [12:0] RECIP_100 = 13'd5243;  // x*RECIP_100 >> 19 == x/100

    typedef struct packed {
        logic signed [12:0] temperature_tenths;
        logic signed [11:0] humidity_tenths;
        logic               unit_is_fahrenheit;
        logic               link_up;
        logic               battery_low;
    } t_sfe_in;

    typedef struct packed {
        logic [55:0] frame_bytes_high;
        logic [63:0] frame_bytes_low;
    } t_sfe_out;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_sfe_digits;

    // Two segment bytes per digit: [7:0] goes to the lower frame byte, [15:8] to the next.
    function automatic logic [15:0] seg_code(input logic [3:0] d);
        logic [15:0] c;
        unique case (d)
            4'd0:    c = {8'h1f, 8'hbf};
            4'd1:    c = {8'h1f, 8'h00};
            4'd2:    c = {8'h17, 8'hfd};
            4'd3:    c = {8'h1f, 8'hf5};
            4'd4:    c = {8'h1f, 8'h47};
            4'd5:    c = {8'h1d, 8'hf7};
            4'd6:    c = {8'h1d, 8'hff};
            4'd7:    c = {8'h1f, 8'h21};
            4'd8:    c = {8'h1f, 8'hff};
            4'd9:    c = {8'h1f, 8'hf7};
            default: c = {8'h1f, 8'hbf};
        endcase
        return c;
    endfunction

endpackage

[rtl/core/sfe_digits.sv]
// Splits a magnitude below 2000 into hundreds, tens and ones decimal digits.
// Depends on sfe_pkg (digit struct, reciprocal constants).
module sfe_digits (
    input  logic [10:0]               i_mag,
    output sfe_pkg::t_sfe_digits      o_digits
);
    import sfe_pkg::*;

    logic [23:0] prod10;
    logic [23:0] prod100;
    logic [7:0]  q10;
    logic [4:0]  q100;
    logic [7:0]  q100_x10;
    logic [10:0] q10_x10;
    logic [7:0]  tens_diff;
    logic [10:0] ones_diff;

    // Constant multiplies run in parallel, no chained divide
    assign prod10   = 24'(i_mag) * 24'(RECIP_10);
    assign prod100  = 24'(i_mag) * 24'(RECIP_100);
    assign q10      = prod10[23:16];
    assign q100     = prod100[23:19];
    assign q100_x10 = 8'(q100) * 8'd10;
    assign q10_x10  = 11'(q10) * 11'd10;
    assign tens_diff = q10 - q100_x10;
    assign ones_diff = i_mag - q10_x10;

    always_comb begin
        // q100 is at most 19, so one conditional subtract gives its last digit
        if (q100 >= 5'd10) begin
            o_digits.hund = 4'(q100 - 5'd10);
        end else begin
            o_digits.hund = q100[3:0];
        end
        o_digits.tens = tens_diff[3:0];
        o_digits.ones = ones_diff[3:0];
    end

endmodule

[rtl/core/sfe_frame.sv]
// Saturates the readings, splits them into digits and assembles the 15-byte frame.
// Depends on sfe_pkg and sfe_digits.
module sfe_frame (
    input  sfe_pkg::t_sfe_in   i_item,
    output sfe_pkg::t_sfe_out  o_frame
);
    import sfe_pkg::*;

    logic signed [12:0] temp_sat;
    logic signed [11:0] hum_sat;
    logic signed [12:0] temp_neg;
    logic [10:0]        temp_mag;
    logic [10:0]        hum_mag;
    t_sfe_digits        temp_dig;
    t_sfe_digits        hum_dig;
    logic [15:0]        seg_th, seg_tt, seg_to;
    logic [15:0]        seg_hh, seg_ht, seg_ho;
    logic [7:0]         frame [FRAME_BYTES];

    always_comb begin
        priority if (i_item.temperature_tenths > TEMP_MAX) begin
            temp_sat = TEMP_MAX;
        end else if (i_item.temperature_tenths < TEMP_MIN) begin
            temp_sat = TEMP_MIN;
        end else begin
            temp_sat = i_item.temperature_tenths;
        end

        priority if (i_item.humidity_tenths > HUM_MAX) begin
            hum_sat = HUM_MAX;
        end else if (i_item.humidity_tenths < 12'sd0) begin
            hum_sat = 12'sd0;
        end else begin
            hum_sat = i_item.humidity_tenths;
        end
    end

    assign temp_neg = -temp_sat;
    assign temp_mag = temp_sat[12] ? temp_neg[10:0] : temp_sat[10:0];
    assign hum_mag  = {1'b0, hum_sat[9:0]};

    sfe_digits u_temp_digits (
        .i_mag    (temp_mag),
        .o_digits (temp_dig)
    );

    sfe_digits u_hum_digits (
        .i_mag    (hum_mag),
        .o_digits (hum_dig)
    );

    assign seg_th = seg_code(temp_dig.hund);
    assign seg_tt = seg_code(temp_dig.tens);
    assign seg_to = seg_code(temp_dig.ones);
    assign seg_hh = seg_code(hum_dig.hund);
    assign seg_ht = seg_code(hum_dig.tens);
    assign seg_ho = seg_code(hum_dig.ones);

    always_comb begin
        priority if (temp_sat[12]) begin
            frame[0] = MARK_MINUS;
        end else if (temp_sat >= TEMP_HUND) begin
            frame[0] = MARK_HUNDREDS;
        end else begin
            frame[0] = MARK_NONE;
        end
        frame[1]  = seg_th[7:0];
        frame[2]  = seg_th[15:8];
        frame[3]  = seg_tt[7:0];
        frame[4]  = seg_tt[15:8] | DOT_MARK;
        frame[5]  = seg_hh[7:0];
        frame[6]  = seg_hh[15:8];
        frame[7]  = seg_ht[7:0];
        frame[8]  = seg_ht[15:8] | DOT_MARK;
        frame[9]  = seg_ho[7:0];
        frame[10] = seg_ho[15:8] | DOT_MARK;   // percent sign
        frame[11] = seg_to[7:0];
        frame[12] = seg_to[15:8];
        frame[13] = ICON_BASE
                  | (i_item.unit_is_fahrenheit ? ICON_FAHR : ICON_CELS)
                  | (i_item.link_up ? ICON_LINK : 8'h00)
                  | (i_item.battery_low ? ICON_BATT : 8'h00);
        frame[14] = TAIL_BYTE;
    end

    always_comb begin
        for (int k = 0; k < LOW_BYTES; k++) begin
            o_frame.frame_bytes_low[8*k +: 8] = frame[k];
        end
        for (int k = 0; k < HIGH_BYTES; k++) begin
            o_frame.frame_bytes_high[8*k +: 8] = frame[LOW_BYTES + k];
        end
    end

endmodule

[rtl/core/segment_frame_encoder_core.sv]
// Segment frame encoder top level: input register, frame logic, result register.
// An accepted beat goes through the input register and then the result register, which drives the strobe.
// Throughput: one beat per cycle; busy is high only while reset is held, the receiver cannot stall.
// Reset (synchronous, active low) clears the valid flags only; payload is not reset.
// Depends on sfe_pkg and sfe_frame.
module segment_frame_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sfe_pkg::t_sfe_in   i_item,
    output logic               o_strobe,
    output sfe_pkg::t_sfe_out  o_result
);
    import sfe_pkg::*;

    logic      r_in_vld;
    t_sfe_in   r_in;
    logic      r_out_vld;
    t_sfe_out  r_out;
    t_sfe_out  n_out;
    logic      accept;

    // A beat offered during reset would be dropped, so refuse it
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    sfe_frame u_frame (
        .i_item  (r_in),
        .o_frame (n_out)
    );

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe)
        else $error("accepted beat produced no result strobe");

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_in_vld))
        else $error("result strobe without a beat in the input register");

    a_fixed_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.frame_bytes_high[55:48] == TAIL_BYTE)
                  && o_result.frame_bytes_high[42] && o_result.frame_bytes_low[37])
        else $error("constant frame bits missing");

    a_one_unit_icon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot(o_result.frame_bytes_high[41:40]))
        else $error("unit icons not exclusive");

endmodule
